// ===== hw/rtl/rf3_pkg.sv =====
`timescale 1ns / 1ps

package rf3_pkg;

	// Default build values
	localparam int DEF_MAX_ROW_LENGTH = 1024;
	localparam int DEF_SAMPLE_BITS    = 16;

	// Fixed field widths
	localparam int COEFF_BITS   = 16;
	localparam int LEN_BITS     = 11;
	localparam int QUEUE_DEPTH  = 4;

	// Rows per frame saturate here
	localparam int ROW_COUNT_LIMIT = 1024;
	localparam int ROW_IDX_BITS    = $clog2(ROW_COUNT_LIMIT);

	// Config port
	localparam int PADDR_BITS = 5;
	localparam int PDATA_BITS = 32;

	// Register indexes (paddr[4:2])
	localparam logic [2:0] REG_LEFT_COEFF   = 3'd0;
	localparam logic [2:0] REG_CENTER_COEFF = 3'd1;
	localparam logic [2:0] REG_RIGHT_COEFF  = 3'd2;
	localparam logic [2:0] REG_ROW_LENGTH   = 3'd3;
	localparam logic [2:0] REG_ROW_COUNT    = 3'd4;

	// Job kinds passed from front to back
	typedef enum logic [1:0] {
		JOB_SINGLE,   // row of one sample: center term only, ends row
		JOB_MID,      // one full three-tap result inside the row
		JOB_LAST      // full result, then the row's last result
	} job_kind_t;

	typedef struct packed {
		job_kind_t kind;
		logic      frame_end;
	} job_ctrl_t;

	typedef struct packed {
		logic row_end;
		logic frame_end;
	} res_flags_t;

	typedef struct packed {
		logic signed [COEFF_BITS-1:0] left;
		logic signed [COEFF_BITS-1:0] center;
		logic signed [COEFF_BITS-1:0] right;
	} coeffs_t;

	typedef struct packed {
		logic [LEN_BITS-1:0] row_length;
		logic [LEN_BITS-1:0] row_count;
	} geom_t;

endpackage

// ===== hw/rtl/rf3_front.sv =====
`timescale 1ns / 1ps

module rf3_front import rf3_pkg::*; #(
	parameter int MAX_ROW_LENGTH = DEF_MAX_ROW_LENGTH,
	parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
	parameter int JOB_W          = $bits(job_ctrl_t) + 3 * SAMPLE_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  geom_t                  geom,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   accept,
	output logic                   job_push,
	output logic [JOB_W-1:0]       job_data
);

	localparam int CLEN_W = $clog2(MAX_ROW_LENGTH + 1);
	localparam int CMP_W  = ((CLEN_W > LEN_BITS) ? CLEN_W : LEN_BITS) + 1;
	localparam int COL_W  = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
	localparam int RCMP_W = LEN_BITS + 1;

	logic [SAMPLE_BITS-1:0]  left_q, pend_q;
	logic [COL_W-1:0]        col_q;
	logic [ROW_IDX_BITS-1:0] row_q;

	logic [CMP_W-1:0]  len_ext, len_eff;
	logic [RCMP_W-1:0] cnt_ext, cnt_eff;
	logic              last, frame_last;
	job_ctrl_t         ctrl;

	// Clamp row length and row count to their legal ranges
	always_comb begin
		len_ext = CMP_W'(geom.row_length);
		if (len_ext == '0) begin
			len_eff = CMP_W'(1);
		end else if (len_ext > CMP_W'(MAX_ROW_LENGTH)) begin
			len_eff = CMP_W'(MAX_ROW_LENGTH);
		end else begin
			len_eff = len_ext;
		end
		cnt_ext = RCMP_W'(geom.row_count);
		if (cnt_ext == '0) begin
			cnt_eff = RCMP_W'(1);
		end else if (cnt_ext > RCMP_W'(ROW_COUNT_LIMIT)) begin
			cnt_eff = RCMP_W'(ROW_COUNT_LIMIT);
		end else begin
			cnt_eff = cnt_ext;
		end
	end

	assign last       = (CMP_W'(col_q) + CMP_W'(1)) >= len_eff;
	assign frame_last = (RCMP_W'(row_q) + RCMP_W'(1)) >= cnt_eff;

	// Classify the beat
	always_comb begin
		ctrl.frame_end = frame_last;
		if (col_q == '0) begin
			ctrl.kind = JOB_SINGLE;
		end else if (last) begin
			ctrl.kind = JOB_LAST;
		end else begin
			ctrl.kind = JOB_MID;
		end
	end

	// The first sample of a longer row only gets held
	assign job_push = accept && !((col_q == '0) && !last);
	assign job_data = {ctrl, left_q, pend_q, sample};

	// Advance row position and neighbor history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			pend_q <= '0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (accept) begin
			if (last) begin
				left_q <= '0;
				pend_q <= '0;
				col_q  <= '0;
				row_q  <= frame_last ? '0 : row_q + ROW_IDX_BITS'(1);
			end else begin
				left_q <= (col_q == '0) ? '0 : pend_q;
				pend_q <= sample;
				col_q  <= col_q + COL_W'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/rf3_fifo.sv =====
`timescale 1ns / 1ps

module rf3_fifo import rf3_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [AW:0]      cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == (AW + 1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			cnt_q <= cnt_q + (AW + 1)'(do_push) - (AW + 1)'(do_pop);
		end
	end

endmodule

// ===== hw/rtl/rf3_back.sv =====
`timescale 1ns / 1ps

module rf3_back import rf3_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int JOB_W       = $bits(job_ctrl_t) + 3 * SAMPLE_BITS,
	parameter int FILT_W      = SAMPLE_BITS + COEFF_BITS + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  coeffs_t           coeffs,
	input  logic [JOB_W-1:0]  job_data,
	input  logic              job_empty,
	output logic              job_pop,
	output logic [FILT_W-1:0] filtered,
	output logic              row_end,
	output logic              frame_end,
	output logic              empty,
	input  logic              pop
);

	localparam int PW = SAMPLE_BITS + COEFF_BITS;

	job_ctrl_t                     jctrl;
	logic signed [SAMPLE_BITS-1:0] j_l, j_p, j_s;
	logic signed [SAMPLE_BITS-1:0] t0, t1, t2;
	logic signed [PW-1:0]          m0, m1, m2;
	logic signed [PW-1:0]          m0_s1, m1_s1, m2_s1;
	logic signed [FILT_W-1:0]      sum;
	logic [FILT_W-1:0]             filt_s2;
	res_flags_t                    flg, flg_s1, flg_s2;
	logic                          phase_q, vld_s1, vld_s2, en, issue;

	assign {jctrl, j_l, j_p, j_s} = job_data;

	// Whole pipe moves when the output register frees up
	assign en      = !vld_s2 || pop;
	assign issue   = en && !job_empty;
	assign job_pop = issue && ((jctrl.kind != JOB_LAST) || phase_q);

	// Pick taps for this result
	always_comb begin
		unique case (jctrl.kind)
			JOB_SINGLE: begin
				t0  = '0;
				t1  = j_s;
				t2  = '0;
				flg = '{row_end: 1'b1, frame_end: jctrl.frame_end};
			end
			JOB_MID: begin
				t0  = j_l;
				t1  = j_p;
				t2  = j_s;
				flg = '{row_end: 1'b0, frame_end: 1'b0};
			end
			JOB_LAST: begin
				if (phase_q) begin
					t0  = j_p;
					t1  = j_s;
					t2  = '0;
					flg = '{row_end: 1'b1, frame_end: jctrl.frame_end};
				end else begin
					t0  = j_l;
					t1  = j_p;
					t2  = j_s;
					flg = '{row_end: 1'b0, frame_end: 1'b0};
				end
			end
			default: begin
				t0  = '0;
				t1  = '0;
				t2  = '0;
				flg = '{row_end: 1'b0, frame_end: 1'b0};
			end
		endcase
	end

	assign m0 = t0 * coeffs.left;
	assign m1 = t1 * coeffs.center;
	assign m2 = t2 * coeffs.right;
	assign sum = FILT_W'(m0_s1) + FILT_W'(m1_s1) + FILT_W'(m2_s1);

	// Stage payload: products, then the sum
	always_ff @(posedge clk) begin
		if (en) begin
			m0_s1   <= m0;
			m1_s1   <= m1;
			m2_s1   <= m2;
			flg_s1  <= flg;
			filt_s2 <= sum;
			flg_s2  <= flg_s1;
		end
	end

	// Track valid beats and the second half of a row-end job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
		end else begin
			if (en) begin
				vld_s1 <= issue;
				vld_s2 <= vld_s1;
			end
			if (issue && (jctrl.kind == JOB_LAST)) begin
				phase_q <= !phase_q;
			end
		end
	end

	assign filtered  = filt_s2;
	assign row_end   = flg_s2.row_end;
	assign frame_end = flg_s2.frame_end;
	assign empty     = !vld_s2;

endmodule

// ===== hw/rtl/row_fir3_zero_edge.sv =====
`timescale 1ns / 1ps

// Channel   Handshake              Beat
// --------  ---------------------  ------------------------------------------
// input     push / full            sample
// result    pop / empty            filtered, row_end, frame_end
// config    psel penable pwrite    paddr, pwdata, prdata (pready tied high)
//
// One sample is taken per cycle while full is low; a result passes through the
// job queue, the product stage and then the sum/output register.
// The last sample of a row longer than one sample makes two results, so the
// back end issues that job twice; the four-entry job queue absorbs the slack.
// full follows the job queue; a stall on pop holds the whole back pipeline.
// Reset clears coefficients to 0/1/0 and row length and count to 1024.

module row_fir3_zero_edge import rf3_pkg::*; #(
	parameter int MAX_ROW_LENGTH = DEF_MAX_ROW_LENGTH,
	parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [PADDR_BITS-1:0]         paddr,
	input  logic [PDATA_BITS-1:0]         pwdata,
	output logic [PDATA_BITS-1:0]         prdata,
	output logic                          pready,
	input  logic [SAMPLE_BITS-1:0]        sample,
	input  logic                          push,
	output logic                          full,
	output logic [SAMPLE_BITS+COEFF_BITS:0] filtered,
	output logic                          row_end,
	output logic                          frame_end,
	output logic                          empty,
	input  logic                          pop
);

	localparam int JOB_W = $bits(job_ctrl_t) + 3 * SAMPLE_BITS;

	coeffs_t          coeffs_q;
	geom_t            geom_q;
	logic [2:0]       reg_idx;
	logic             wr_en, accept, job_push, job_full, job_pop, job_empty;
	logic [JOB_W-1:0] job_in, job_out;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// Write config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeffs_q.left     <= '0;
			coeffs_q.center   <= COEFF_BITS'(1);
			coeffs_q.right    <= '0;
			geom_q.row_length <= LEN_BITS'(1024);
			geom_q.row_count  <= LEN_BITS'(1024);
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_LEFT_COEFF:   coeffs_q.left     <= pwdata[COEFF_BITS-1:0];
				REG_CENTER_COEFF: coeffs_q.center   <= pwdata[COEFF_BITS-1:0];
				REG_RIGHT_COEFF:  coeffs_q.right    <= pwdata[COEFF_BITS-1:0];
				REG_ROW_LENGTH:   geom_q.row_length <= pwdata[LEN_BITS-1:0];
				REG_ROW_COUNT:    geom_q.row_count  <= pwdata[LEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (reg_idx)
			REG_LEFT_COEFF:   prdata = PDATA_BITS'(coeffs_q.left);
			REG_CENTER_COEFF: prdata = PDATA_BITS'(coeffs_q.center);
			REG_RIGHT_COEFF:  prdata = PDATA_BITS'(coeffs_q.right);
			REG_ROW_LENGTH:   prdata = PDATA_BITS'(geom_q.row_length);
			REG_ROW_COUNT:    prdata = PDATA_BITS'(geom_q.row_count);
			default:          prdata = '0;
		endcase
	end

	assign full   = job_full;
	assign accept = push && !job_full;

	rf3_front #(
		.MAX_ROW_LENGTH (MAX_ROW_LENGTH),
		.SAMPLE_BITS    (SAMPLE_BITS),
		.JOB_W          (JOB_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.geom     (geom_q),
		.sample   (sample),
		.accept   (accept),
		.job_push (job_push),
		.job_data (job_in)
	);

	rf3_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (QUEUE_DEPTH)
	) u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.din    (job_in),
		.full   (job_full),
		.pop    (job_pop),
		.dout   (job_out),
		.empty  (job_empty)
	);

	rf3_back #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.JOB_W       (JOB_W),
		.FILT_W      (SAMPLE_BITS + COEFF_BITS + 1)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.coeffs    (coeffs_q),
		.job_data  (job_out),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.filtered  (filtered),
		.row_end   (row_end),
		.frame_end (frame_end),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

// ===== tb/tb_row_fir3_zero_edge.sv =====
`timescale 1ns / 1ps

module tb_row_fir3_zero_edge;
	import rf3_pkg::*;

	localparam int HALF_PERIOD   = 6;
	localparam int CLK_PERIOD    = 2 * HALF_PERIOD;
	localparam int SMP_BITS      = DEF_SAMPLE_BITS;
	localparam int FILT_BITS     = SMP_BITS + COEFF_BITS + 1;
	localparam int MAX_ROW_LEN   = DEF_MAX_ROW_LENGTH;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 300;
	localparam int LIMIT_CYCLES  = 400000;

	// No register lives at this index
	localparam logic [2:0] REG_UNUSED = 3'd7;

	typedef enum logic [1:0] {
		ACT_WRITE,     // register write while the block is idle
		ACT_SAMPLE,    // sample beat, results from the predictor
		ACT_CHECKED    // sample beat with one result typed in below
	} act_t;

	typedef struct packed {
		logic signed [FILT_BITS-1:0] filtered;
		logic                        row_end;
		logic                        frame_end;
	} fir_out_t;

	typedef struct packed {
		act_t                        act;
		logic [2:0]                  reg_idx;
		logic [PDATA_BITS-1:0]       value;
		logic [SMP_BITS-1:0]         smp;
		logic signed [FILT_BITS-1:0] filt;
		logic                        re;
		logic                        fe;
	} plan_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [PADDR_BITS-1:0]   paddr;
	logic [PDATA_BITS-1:0]   pwdata;
	logic [PDATA_BITS-1:0]   prdata;
	logic                    pready;
	logic [SMP_BITS-1:0]     sample;
	logic                    push;
	logic                    full;
	logic [FILT_BITS-1:0]    filtered;
	logic                    row_end;
	logic                    frame_end;
	logic                    empty;
	logic                    pop;

	// Predictor copy of configuration and row state
	logic signed [COEFF_BITS-1:0] coef_left;
	logic signed [COEFF_BITS-1:0] coef_center;
	logic signed [COEFF_BITS-1:0] coef_right;
	logic [LEN_BITS-1:0]          row_len_reg;
	logic [LEN_BITS-1:0]          row_cnt_reg;
	longint                       smp_left;
	longint                       smp_pend;
	int                           col_idx;
	int                           row_idx;

	fir_out_t expected_q[$];
	int       fail_count = 0;
	int       tx_idle_pct;
	int       rx_idle_pct;
	bit       rx_hold_req = 1'b0;

	// Directed rows: reset state, short rows, extremes, clamped geometry
	plan_row_t directed_plan [0:31] = '{
		'{ACT_SAMPLE,  REG_LEFT_COEFF,   32'h0,         16'h7FFF, 33'sd0,           1'b0, 1'b0},
		'{ACT_CHECKED, REG_LEFT_COEFF,   32'h0,         16'h8000, 33'sd32767,       1'b0, 1'b0},
		'{ACT_WRITE,   REG_ROW_LENGTH,   32'hFFFF_F801, 16'h0,    33'sd0,           1'b0, 1'b0},
		'{ACT_SAMPLE,  REG_LEFT_COEFF,   32'h0,         16'h0005, 33'sd0,           1'b0, 1'b0},
		'{ACT_WRITE,   REG_CENTER_COEFF, 32'hFFFF_8000, 16'h0,    33'sd0,           1'b0, 1'b0},
		'{ACT_WRITE,   REG_ROW_COUNT,    32'h0000_0002, 16'h0,    33'sd0,           1'b0, 1'b0},
		'{ACT_CHECKED, REG_LEFT_COEFF,   32'h0,         16'h7FFF, -33'sd1073709056, 1'b1, 1'b1},
		'{ACT_CHECKED, REG_LEFT_COEFF,   32'h0,         16'h8000, 33'sd1073741824,  1'b1, 1'b0},
		'{ACT_WRITE,   REG_ROW_COUNT,    32'h0000_0000, 16'h0,    33'sd0,           1'b0, 1'b0},
		'{ACT_CHECKED, REG_LEFT_COEFF,   32'h0,         16'h0000, 33'sd0,           1'b1, 1'b1},
		'{ACT_CHECKED, REG_LEFT_COEFF,   32'h0,         16'hFFFF, 33'sd32768,       1'b1, 1'b1},
		'{ACT_WRITE,   REG_ROW_LENGTH,   32'h0000_F800, 16'h0,    33'sd0,           1'b0, 1'b0},
		'{ACT_CHECKED, REG_LEFT_COEFF,   32'h0,         16'h0001, -33'sd32768,      1'b1, 1'b1},
		'{ACT_WRITE,   REG_ROW_COUNT,    32'h0000_07FF, 16'h0,    33'sd0,           1'b0, 1'b0},
		'{ACT_WRITE,   REG_ROW_LENGTH,   32'h0000_07FF, 16'h0,    33'sd0,           1'b0, 1'b0},
		'{ACT_WRITE,   REG_LEFT_COEFF,   32'h0000_8000, 16'h0,    33'sd0,           1'b0, 1'b0},
		'{ACT_WRITE,   REG_RIGHT_COEFF,  32'h0000_8000, 16'h0,    33'sd0,           1'b0, 1'b0},
		'{ACT_SAMPLE,  REG_LEFT_COEFF,   32'h0,         16'h8000, 33'sd0,           1'b0, 1'b0},
		'{ACT_SAMPLE,  REG_LEFT_COEFF,   32'h0,         16'h8000, 33'sd0,           1'b0, 1'b0},
		'{ACT_CHECKED, REG_LEFT_COEFF,   32'h0,         16'h8000, 33'sd3221225472,  1'b0, 1'b0},
		'{ACT_WRITE,   REG_ROW_LENGTH,   32'h0000_0003, 16'h0,    33'sd0,           1'b0, 1'b0},
		'{ACT_WRITE,   REG_LEFT_COEFF,   32'h0000_0001, 16'h0,    33'sd0,           1'b0, 1'b0},
		'{ACT_WRITE,   REG_CENTER_COEFF, 32'h0000_0002, 16'h0,    33'sd0,           1'b0, 1'b0},
		'{ACT_WRITE,   REG_RIGHT_COEFF,  32'h0000_0003, 16'h0,    33'sd0,           1'b0, 1'b0},
		'{ACT_WRITE,   REG_UNUSED,       32'h0000_1234, 16'h0,    33'sd0,           1'b0, 1'b0},
		'{ACT_SAMPLE,  REG_LEFT_COEFF,   32'h0,         16'h0007, 33'sd0,           1'b0, 1'b0},
		'{ACT_SAMPLE,  REG_LEFT_COEFF,   32'h0,         16'h0002, 33'sd0,           1'b0, 1'b0},
		'{ACT_CHECKED, REG_LEFT_COEFF,   32'h0,         16'h0003, 33'sd13,          1'b0, 1'b0},
		'{ACT_SAMPLE,  REG_LEFT_COEFF,   32'h0,         16'h0004, 33'sd0,           1'b0, 1'b0},
		'{ACT_WRITE,   REG_ROW_LENGTH,   32'h0000_0002, 16'h0,    33'sd0,           1'b0, 1'b0},
		'{ACT_SAMPLE,  REG_LEFT_COEFF,   32'h0,         16'h000A, 33'sd0,           1'b0, 1'b0},
		'{ACT_SAMPLE,  REG_LEFT_COEFF,   32'h0,         16'h0014, 33'sd0,           1'b0, 1'b0}
	};

	row_fir3_zero_edge dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.sample    (sample),
		.push      (push),
		.full      (full),
		.filtered  (filtered),
		.row_end   (row_end),
		.frame_end (frame_end),
		.empty     (empty),
		.pop       (pop)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Close the current row; return 1 when it ends the frame
	function automatic bit close_row(int cnt);
		bit fe;
		fe = (row_idx + 1 >= cnt);
		col_idx  = 0;
		smp_left = 0;
		smp_pend = 0;
		row_idx  = fe ? 0 : row_idx + 1;
		return fe;
	endfunction

	// Advance the row filter by one sample and give the results it releases
	task automatic fir_predict(input logic [SMP_BITS-1:0] s_raw, output int n,
		output fir_out_t r0, output fir_out_t r1);
		longint s;
		longint cl;
		longint cc;
		longint cr;
		longint sum;
		int     len;
		int     cnt;
		bit     last;
		s   = longint'($signed(s_raw));
		cl  = longint'(coef_left);
		cc  = longint'(coef_center);
		cr  = longint'(coef_right);
		len = (row_len_reg == 0) ? 1 : (row_len_reg > MAX_ROW_LEN) ? MAX_ROW_LEN : row_len_reg;
		cnt = (row_cnt_reg == 0) ? 1 :
			(row_cnt_reg > ROW_COUNT_LIMIT) ? ROW_COUNT_LIMIT : row_cnt_reg;
		last = (col_idx + 1 >= len);
		n  = 0;
		r0 = '0;
		r1 = '0;
		if (col_idx == 0) begin
			if (last) begin
				sum          = s * cc;
				r0.filtered  = sum[FILT_BITS-1:0];
				r0.row_end   = 1'b1;
				r0.frame_end = close_row(cnt);
				n = 1;
			end else begin
				// hold the first sample of the row
				smp_left = 0;
				smp_pend = s;
				col_idx  = 1;
			end
		end else begin
			sum         = smp_left * cl + smp_pend * cc + s * cr;
			r0.filtered = sum[FILT_BITS-1:0];
			n = 1;
			if (last) begin
				// the row's own last position has no right neighbor
				sum          = smp_pend * cl + s * cc;
				r1.filtered  = sum[FILT_BITS-1:0];
				r1.row_end   = 1'b1;
				r1.frame_end = close_row(cnt);
				n = 2;
			end else begin
				smp_left = smp_pend;
				smp_pend = s;
				col_idx++;
			end
		end
	endtask

	// Offer one sample beat, then predict once it is taken
	task automatic send_sample(input logic [SMP_BITS-1:0] s, input bit use_typed,
		input fir_out_t typed_res);
		int       n;
		fir_out_t r0;
		fir_out_t r1;
		while ($urandom_range(99) < tx_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push   <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (full)
			@(posedge clk);
		fir_predict(s, n, r0, r1);
		if (use_typed) begin
			expected_q.push_back(typed_res);
		end else begin
			if (n > 0)
				expected_q.push_back(r0);
			if (n > 1)
				expected_q.push_back(r1);
		end
	endtask

	// Drop push, wait for every result, then let the pipeline settle
	task automatic wait_drained();
		push <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Setup and access cycle; the register takes the value at the access edge
	task automatic write_reg(input logic [2:0] idx, input logic [PDATA_BITS-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_LEFT_COEFF:   coef_left   = value[COEFF_BITS-1:0];
			REG_CENTER_COEFF: coef_center = value[COEFF_BITS-1:0];
			REG_RIGHT_COEFF:  coef_right  = value[COEFF_BITS-1:0];
			REG_ROW_LENGTH:   row_len_reg = value[LEN_BITS-1:0];
			REG_ROW_COUNT:    row_cnt_reg = value[LEN_BITS-1:0];
			default: ;
		endcase
		// idle so the next transfer starts on a later edge
		@(posedge clk);
	endtask

	function automatic logic [SMP_BITS-1:0] pick_sample();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return SMP_BITS'($urandom());
		endcase
	endfunction

	function automatic logic [COEFF_BITS-1:0] pick_coeff();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return COEFF_BITS'($urandom_range(7));
			default: return COEFF_BITS'($urandom());
		endcase
	endfunction

	function automatic logic [LEN_BITS-1:0] pick_length();
		case ($urandom_range(11))
			0: return 11'd0;
			1: return 11'd1;
			2: return 11'd2;
			3: return 11'd2047;
			4: return LEN_BITS'($urandom_range(3, 40));
			default: return LEN_BITS'($urandom_range(1, 8));
		endcase
	endfunction

	function automatic logic [LEN_BITS-1:0] pick_count();
		case ($urandom_range(7))
			0: return 11'd0;
			1: return 11'd2047;
			default: return LEN_BITS'($urandom_range(1, 4));
		endcase
	endfunction

	// New random setting, then a run of random samples
	task automatic run_phase(input int items, input bit long_rows);
		logic [PDATA_BITS-1:0] v;
		fir_out_t              none;
		none = '0;
		wait_drained();
		v = $urandom();
		v[COEFF_BITS-1:0] = pick_coeff();
		write_reg(REG_LEFT_COEFF, v);
		v = $urandom();
		v[COEFF_BITS-1:0] = pick_coeff();
		write_reg(REG_CENTER_COEFF, v);
		v = $urandom();
		v[COEFF_BITS-1:0] = pick_coeff();
		write_reg(REG_RIGHT_COEFF, v);
		v = $urandom();
		v[LEN_BITS-1:0] = long_rows ? 11'd1024 : pick_length();
		write_reg(REG_ROW_LENGTH, v);
		v = $urandom();
		v[LEN_BITS-1:0] = long_rows ? 11'd1 : pick_count();
		write_reg(REG_ROW_COUNT, v);
		if ($urandom_range(3) == 0)
			write_reg(REG_UNUSED, $urandom());
		// hold off the receiver so the job queue fills and full stalls the sender
		if (long_rows)
			rx_hold_req = 1'b1;
		repeat (items)
			send_sample(pick_sample(), 1'b0, none);
	endtask

	// Receiver: pop at random, check each result beat against the oldest expectation
	initial begin
		int       hold_left;
		fir_out_t want;
		hold_left = 0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				if (expected_q.size() == 0) begin
					$error("result beat with none expected: filtered %0d row_end %0b frame_end %0b",
						$signed(filtered), row_end, frame_end);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (filtered !== want.filtered) begin
						$error("filtered: expected %0d, actual %0d",
							$signed(want.filtered), $signed(filtered));
						fail_count++;
					end
					if (row_end !== want.row_end) begin
						$error("row_end: expected %0b, actual %0b", want.row_end, row_end);
						fail_count++;
					end
					if (frame_end !== want.frame_end) begin
						$error("frame_end: expected %0b, actual %0b", want.frame_end, frame_end);
						fail_count++;
					end
				end
			end
			if (rx_hold_req) begin
				hold_left   = HOLD_CYCLES;
				rx_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Stimulus
	initial begin
		fir_out_t typed_res;
		arst_n  <= 1'b0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		sample  <= '0;
		push    <= 1'b0;
		coef_left   = 16'sd0;
		coef_center = 16'sd1;
		coef_right  = 16'sd0;
		row_len_reg = 11'd1024;
		row_cnt_reg = 11'd1024;
		smp_left = 0;
		smp_pend = 0;
		col_idx  = 0;
		row_idx  = 0;
		tx_idle_pct = 11;
		rx_idle_pct = 69;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows
		for (int k = 0; k < $size(directed_plan); k++) begin
			typed_res.filtered  = directed_plan[k].filt;
			typed_res.row_end   = directed_plan[k].re;
			typed_res.frame_end = directed_plan[k].fe;
			case (directed_plan[k].act)
				ACT_WRITE: begin
					wait_drained();
					write_reg(directed_plan[k].reg_idx, directed_plan[k].value);
				end
				ACT_CHECKED: send_sample(directed_plan[k].smp, 1'b1, typed_res);
				default: send_sample(directed_plan[k].smp, 1'b0, typed_res);
			endcase
		end

		// Random: slow receiver, then slow sender, then no idling with a long hold-off
		run_phase(40, 1'b0);
		run_phase(40, 1'b0);
		tx_idle_pct = 69;
		rx_idle_pct = 11;
		run_phase(40, 1'b0);
		run_phase(40, 1'b0);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_phase(1030, 1'b1);

		wait_drained();
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(CLK_PERIOD * LIMIT_CYCLES);
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== row_fir3_zero_edge.f =====
hw/rtl/rf3_pkg.sv
hw/rtl/rf3_front.sv
hw/rtl/rf3_fifo.sv
hw/rtl/rf3_back.sv
hw/rtl/row_fir3_zero_edge.sv
tb/tb_row_fir3_zero_edge.sv
